[rtl/wrrm_pkg.sv]
// Shared types and constants for the weighted run region merger.
package wrrm_pkg;

    localparam int MAX_RUNS    = 64;
    localparam int MAX_COLUMNS = 65536;
    localparam int RUN_AW      = $clog2(MAX_RUNS);
    localparam int CNT_W       = RUN_AW + 1;
    localparam int COL_W       = $clog2(MAX_COLUMNS) + 1;
    localparam int POS_W       = 16;
    localparam int WGT_W       = 26;
    localparam int WF_W        = 10;
    localparam int ML_W        = 16;

    localparam logic CFG_BAD_SCALE   = 1'b0;
    localparam logic CFG_MERGE_FLOOR = 1'b1;

    typedef struct packed {
        logic column_good;
        logic last_column;
    } col_item_t;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
        logic             good;
        logic [WGT_W-1:0] weight;
    } run_entry_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_SCAN,
        ST_DECIDE,
        ST_MERGE,
        ST_PLACE,
        ST_SHIFT,
        ST_EMIT_RD,
        ST_EMIT,
        ST_OVF
    } eng_state_t;

endpackage

[rtl/wrrm_front.sv]
// Input stage: accepts columns and holds them in a short queue for the engine.
module wrrm_front
    import wrrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  col_item_t s_item,
    output logic      q_valid,
    input  logic      q_ready,
    output col_item_t q_item
);

    col_item_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign s_tready = (cnt_reg != 3'd4);
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

endmodule

[rtl/wrrm_engine.sv]
// Run builder, merge reduction and result sequencer.
module wrrm_engine
    import wrrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  col_item_t          q_item,
    input  logic [WF_W-1:0]    bad_scale,
    input  logic [ML_W-1:0]    merge_floor,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    run_entry_t        run_mem [MAX_RUNS];
    run_entry_t        rd_reg;

    eng_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [COL_W-1:0]  col_reg;
    logic              ovf_reg;
    logic [POS_W-1:0]  tail_start_reg;
    logic              tail_good_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic              rv_reg;
    logic [RUN_AW-1:0] ridx_reg;
    logic [RUN_AW-1:0] best_reg, lo_reg, hi_reg;
    logic [WGT_W-1:0]  bw_reg, sum_reg;
    logic              bgood_reg;
    logic [POS_W-1:0]  mstart_reg, mstop_reg;
    logic              obusy_reg;

    logic              take;
    logic              out_free;
    logic              load_out;
    logic [CNT_W-1:0]  last_idx;
    logic [RUN_AW-1:0] last_a;
    logic              extend;
    logic              col_ok;
    logic              scan_go;
    logic              shift_done;
    logic [RUN_AW-1:0] gap;
    logic [RUN_AW-1:0] lo_calc, hi_calc;
    logic [POS_W:0]    len_ext;
    logic [POS_W+WF_W:0] prod;
    logic [WGT_W-1:0]  ext_weight;
    logic              rd_en;
    logic [RUN_AW-1:0] rd_addr;
    logic              wr_en;
    logic [RUN_AW-1:0] wr_addr;
    run_entry_t        wr_data;

    assign last_idx   = cnt_reg - CNT_W'(1);
    assign last_a     = last_idx[RUN_AW-1:0];
    assign out_free   = !obusy_reg || m_tready;
    assign take       = q_valid && (state_reg == ST_FILL);
    assign extend     = (cnt_reg != '0) && (tail_good_reg == q_item.column_good);
    assign col_ok     = !ovf_reg && (col_reg < COL_W'(MAX_COLUMNS));
    assign scan_go    = !ovf_reg && (cnt_reg >= CNT_W'(2));
    assign shift_done = (iss_reg >= cnt_reg) && !rv_reg;
    assign gap        = hi_reg - lo_reg;
    assign lo_calc    = (best_reg != '0) ? best_reg - 1'b1 : best_reg;
    assign hi_calc    = ({1'b0, best_reg} != last_idx) ? best_reg + 1'b1 : best_reg;
    assign len_ext    = {1'b0, col_reg[POS_W-1:0]} - {1'b0, tail_start_reg} + (POS_W+1)'(1);

    always_comb
    begin
        prod       = (POS_W+WF_W+1)'(len_ext) * (POS_W+WF_W+1)'(bad_scale);
        ext_weight = q_item.column_good ? WGT_W'(len_ext) : prod[WGT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= run_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (take && q_item.last_column)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ovf_reg)
                begin
                    state_next = ST_OVF;
                end
                else if (cnt_reg < CNT_W'(2))
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (rv_reg && {1'b0, ridx_reg} == last_idx)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (bw_reg < WGT_W'(merge_floor)) ? ST_MERGE : ST_EMIT_RD;
            end
            ST_MERGE:
            begin
                if (rv_reg && ridx_reg == hi_reg)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ({1'b0, ridx_reg} == last_idx) ? ST_FILL : ST_EMIT_RD;
                end
            end
            ST_OVF:
            begin
                if (out_free)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        q_ready  = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = iss_reg[RUN_AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = ridx_reg - gap;
        wr_data  = rd_reg;
        case (state_reg)
            ST_FILL:
            begin
                q_ready = 1'b1;
                if (take && col_ok)
                begin
                    if (extend)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = last_a;
                        wr_data.start  = tail_start_reg;
                        wr_data.stop   = col_reg[POS_W-1:0];
                        wr_data.good   = q_item.column_good;
                        wr_data.weight = ext_weight;
                    end
                    else if (cnt_reg < CNT_W'(MAX_RUNS))
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = cnt_reg[RUN_AW-1:0];
                        wr_data.start  = col_reg[POS_W-1:0];
                        wr_data.stop   = col_reg[POS_W-1:0];
                        wr_data.good   = q_item.column_good;
                        wr_data.weight = q_item.column_good ?
                            WGT_W'(1) : WGT_W'(bad_scale);
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en = scan_go && (iss_reg < cnt_reg);
            end
            ST_MERGE:
            begin
                rd_en = (iss_reg <= {1'b0, hi_reg});
            end
            ST_PLACE:
            begin
                wr_en          = 1'b1;
                wr_addr        = lo_reg;
                wr_data.start  = mstart_reg;
                wr_data.stop   = mstop_reg;
                wr_data.good   = !bgood_reg;
                wr_data.weight = sum_reg;
            end
            ST_SHIFT:
            begin
                rd_en = (iss_reg < cnt_reg);
                wr_en = rv_reg;
            end
            ST_EMIT_RD:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT:
            begin
                load_out = out_free;
            end
            ST_OVF:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            cnt_reg        <= '0;
            col_reg        <= '0;
            ovf_reg        <= 1'b0;
            tail_start_reg <= '0;
            tail_good_reg  <= 1'b0;
            iss_reg        <= '0;
            rv_reg         <= 1'b0;
            ridx_reg       <= '0;
            best_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            bw_reg         <= '0;
            sum_reg        <= '0;
            bgood_reg      <= 1'b0;
            mstart_reg     <= '0;
            mstop_reg      <= '0;
            obusy_reg      <= 1'b0;
            m_tdata        <= '0;
            m_tlast        <= 1'b0;
            m_tuser        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rd_en;
            obusy_reg <= load_out || (obusy_reg && !m_tready);
            if (rd_en)
            begin
                ridx_reg <= rd_addr;
            end
            case (state_reg)
                ST_FILL:
                begin
                    iss_reg <= '0;
                    if (take && !ovf_reg)
                    begin
                        if (col_reg >= COL_W'(MAX_COLUMNS))
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else if (extend)
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                        else if (cnt_reg >= CNT_W'(MAX_RUNS))
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg        <= cnt_reg + CNT_W'(1);
                            col_reg        <= col_reg + COL_W'(1);
                            tail_start_reg <= col_reg[POS_W-1:0];
                            tail_good_reg  <= q_item.column_good;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (rv_reg && (ridx_reg == '0 || rd_reg.weight < bw_reg))
                    begin
                        bw_reg    <= rd_reg.weight;
                        best_reg  <= ridx_reg;
                        bgood_reg <= rd_reg.good;
                    end
                end
                ST_DECIDE:
                begin
                    lo_reg  <= lo_calc;
                    hi_reg  <= hi_calc;
                    sum_reg <= '0;
                    iss_reg <= (state_next == ST_MERGE) ? {1'b0, lo_calc} : '0;
                end
                ST_MERGE:
                begin
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (rv_reg)
                    begin
                        sum_reg <= sum_reg + rd_reg.weight;
                        if (ridx_reg == lo_reg)
                        begin
                            mstart_reg <= rd_reg.start;
                        end
                        if (ridx_reg == hi_reg)
                        begin
                            mstop_reg <= rd_reg.stop;
                        end
                    end
                end
                ST_PLACE:
                begin
                    iss_reg <= {1'b0, hi_reg} + CNT_W'(1);
                end
                ST_SHIFT:
                begin
                    if (shift_done)
                    begin
                        cnt_reg <= cnt_reg - {1'b0, gap};
                        iss_reg <= '0;
                    end
                    else if (rd_en)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tdata <= {5'd0, rd_reg.weight, rd_reg.good,
                                    rd_reg.stop, rd_reg.start};
                        m_tlast <= ({1'b0, ridx_reg} == last_idx);
                        m_tuser <= 1'b0;
                        if ({1'b0, ridx_reg} == last_idx)
                        begin
                            cnt_reg <= '0;
                            col_reg <= '0;
                            ovf_reg <= 1'b0;
                            iss_reg <= '0;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + CNT_W'(1);
                        end
                    end
                end
                ST_OVF:
                begin
                    if (out_free)
                    begin
                        m_tdata <= '0;
                        m_tlast <= 1'b0;
                        m_tuser <= 1'b1;
                        cnt_reg <= '0;
                        col_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = obusy_reg;

endmodule

[rtl/weighted_run_region_merger_top.sv]
// Columns are taken at one per cycle through a four-entry queue into a run table of up to
// 64 runs kept in a memory with registered reads. After a last column the input stalls
// while the reduction runs: a scan reads every run to find the lightest, a merge then reads,
// sums and writes back its two or three runs and moves the runs behind it down, and each
// scan of two or more runs ends with a decision whether to merge. Results are read back
// one at a time, the next only once the previous one has entered the output register; an
// overflowed block gives one all-zero result with tuser set after its last column.
// tdata: run_start, run_stop, run_good, run_weight.
module weighted_run_region_merger_top
    import wrrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // column_good
    input  logic        s_axis_tlast,   // last_column
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // run_start, run_stop, run_good, run_weight
    output logic        m_axis_tlast,   // last_run
    output logic        m_axis_tuser,   // overflow
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [WF_W-1:0] bad_scale_reg;
    logic [ML_W-1:0] merge_floor_reg;
    col_item_t       s_item, q_item;
    logic            q_valid, q_ready;

    assign s_item.column_good = s_axis_tdata[0];
    assign s_item.last_column = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_scale_reg   <= WF_W'(10);
            merge_floor_reg <= ML_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAD_SCALE:   bad_scale_reg   <= cfg_data[WF_W-1:0];
                CFG_MERGE_FLOOR: merge_floor_reg <= cfg_data;
                default:         merge_floor_reg <= merge_floor_reg;
            endcase
        end
    end

    wrrm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    wrrm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .bad_scale   (bad_scale_reg),
        .merge_floor (merge_floor_reg),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tlast     (m_axis_tlast),
        .m_tuser     (m_axis_tuser)
    );

endmodule

[rtl/wrrm_checker.sv]
// Port-level checks for the weighted run region merger.
module wrrm_checker
    import wrrm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output not held");
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0 && !m_axis_tlast)
        else $error("overflow result not zero");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] >= m_axis_tdata[15:0])
        else $error("run stop before start");

endmodule

bind weighted_run_region_merger_top wrrm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the weighted run region merger.
module tb_top
    import wrrm_pkg::*;
();

    typedef struct {
        logic [15:0] start;
        logic [15:0] stop;
        logic        good;
        logic [25:0] weight;
        logic        last;
        logic        ovf;
    } run_result_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    weighted_run_region_merger_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    int unsigned factor_q;
    int unsigned min_len_q;
    int unsigned span_start [MAX_RUNS];
    int unsigned span_stop [MAX_RUNS];
    bit          span_good [MAX_RUNS];
    int unsigned span_weight [MAX_RUNS];
    int unsigned span_count;
    int unsigned col_pos;
    bit          capacity_hit;

    col_item_t   pending_columns[$];
    run_result_t expected_runs[$];
    col_item_t   cur_column;
    bit          column_taken;
    bit          quiet;
    int          src_gap;
    int          sink_gap;
    int          errors;
    int          cycles;
    int          items_queued;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic int unsigned span_weigh(int unsigned len, bit good);
        return good ? len : len * factor_q;
    endfunction

    task automatic merge_span(int unsigned k);
        int unsigned lo;
        int unsigned hi;
        int unsigned sum;
        int unsigned gap;
        lo = (k > 0) ? k - 1 : k;
        hi = (k + 1 < span_count) ? k + 1 : k;
        sum = 0;
        for (int unsigned i = lo; i <= hi; i++)
            sum += span_weight[i];
        span_stop[lo] = span_stop[hi];
        span_weight[lo] = sum;
        span_good[lo] = !span_good[k];
        gap = hi - lo;
        for (int unsigned i = hi + 1; i < span_count; i++)
        begin
            span_start[i - gap] = span_start[i];
            span_stop[i - gap] = span_stop[i];
            span_good[i - gap] = span_good[i];
            span_weight[i - gap] = span_weight[i];
        end
        span_count -= gap;
    endtask

    task automatic predict_column(col_item_t c);
        int unsigned k;
        run_result_t r;
        if (!capacity_hit)
        begin
            if (col_pos >= MAX_COLUMNS)
                capacity_hit = 1'b1;
            else if (span_count > 0 && span_good[span_count - 1] == c.column_good)
            begin
                k = span_count - 1;
                span_stop[k] = col_pos;
                span_weight[k] = span_weigh(col_pos - span_start[k] + 1, c.column_good);
                col_pos++;
            end
            else if (span_count >= MAX_RUNS)
                capacity_hit = 1'b1;
            else
            begin
                span_start[span_count] = col_pos;
                span_stop[span_count] = col_pos;
                span_good[span_count] = c.column_good;
                span_weight[span_count] = span_weigh(1, c.column_good);
                span_count++;
                col_pos++;
            end
        end
        if (!c.last_column)
            return;
        if (capacity_hit)
        begin
            r = '{start: '0, stop: '0, good: 1'b0, weight: '0, last: 1'b0, ovf: 1'b1};
            expected_runs.insert(expected_runs.size(), r);
        end
        else
        begin
            while (span_count >= 2)
            begin
                k = 0;
                for (int unsigned i = 1; i < span_count; i++)
                    if (span_weight[i] < span_weight[k])
                        k = i;
                if (span_weight[k] >= min_len_q)
                    break;
                merge_span(k);
            end
            for (int unsigned i = 0; i < span_count; i++)
            begin
                r.start = span_start[i][15:0];
                r.stop = span_stop[i][15:0];
                r.good = span_good[i];
                r.weight = span_weight[i][25:0];
                r.last = (i + 1 == span_count);
                r.ovf = 1'b0;
                expected_runs.insert(expected_runs.size(), r);
            end
        end
        span_count = 0;
        col_pos = 0;
        capacity_hit = 1'b0;
    endtask

    // source side
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || column_taken))
        begin
            column_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_columns.size() > 0)
            begin
                cur_column = pending_columns.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, cur_column.column_good};
                s_axis_tlast <= cur_column.last_column;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // sink side
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            sink_gap = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        run_result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_column(cur_column);
                column_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("unexpected result transfer: tdata %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_runs.pop_front();
                    if (m_axis_tdata[15:0] !== e.start)
                    begin
                        $error("run_start: expected %0d, got %0d", e.start, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:16] !== e.stop)
                    begin
                        $error("run_stop: expected %0d, got %0d", e.stop, m_axis_tdata[31:16]);
                        errors++;
                    end
                    if (m_axis_tdata[32] !== e.good)
                    begin
                        $error("run_good: expected %0d, got %0d", e.good, m_axis_tdata[32]);
                        errors++;
                    end
                    if (m_axis_tdata[58:33] !== e.weight)
                    begin
                        $error("run_weight: expected %0d, got %0d", e.weight,
                            m_axis_tdata[58:33]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $error("last_run: expected %0d, got %0d", e.last, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser !== e.ovf)
                    begin
                        $error("overflow: expected %0d, got %0d", e.ovf, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic idx, int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        if (idx == CFG_BAD_SCALE)
            factor_q = value & 32'h3FF;
        else
            min_len_q = value & 32'hFFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int unsigned wf, int unsigned ml);
        write_reg(CFG_BAD_SCALE, wf);
        write_reg(CFG_MERGE_FLOOR, ml);
    endtask

    task automatic add_column(bit good, bit last);
        col_item_t c;
        c.column_good = good;
        c.last_column = last;
        pending_columns.insert(pending_columns.size(), c);
        items_queued++;
    endtask

    task automatic add_block(int runs, int max_len);
        bit flag;
        int len;
        flag = $urandom_range(0, 1);
        for (int r = 0; r < runs; r++)
        begin
            len = $urandom_range(1, max_len);
            for (int i = 0; i < len; i++)
                add_column(flag, (r == runs - 1) && (i == len - 1));
            flag = !flag;
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_columns.size() > 0 || s_axis_tvalid || expected_runs.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BAD_SCALE;
        cfg_data = '0;
        factor_q = 10;
        min_len_q = 100;
        span_count = 0;
        col_pos = 0;
        capacity_hit = 1'b0;
        column_taken = 1'b0;
        quiet = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        errors = 0;
        cycles = 0;
        items_queued = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: single columns and a short mixed block
        add_column(1'b1, 1'b1);
        add_column(1'b0, 1'b1);
        add_block(6, 3);
        drain();

        set_regs(0, 0);
        add_block(8, 4);
        drain();

        set_regs(1023, 65535);
        add_block(10, 3);
        drain();

        set_regs(1, 1);
        add_block(12, 2);
        drain();

        // run table overflow, then ignored columns until the block ends
        set_regs(3, 5);
        for (int i = 0; i < 70; i++)
            add_column(i[0], i == 69);
        add_block(64, 1);
        drain();

        while (items_queued < 400)
        begin
            set_regs($urandom_range(0, 1023), $urandom_range(0, 60));
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 9) == 0)
                    add_block($urandom_range(60, 70), 2);
                else
                    add_block($urandom_range(1, 20), $urandom_range(1, 8));
            end
            if (items_queued >= 320)
                quiet = 1'b1;
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/wrrm_pkg.sv
rtl/wrrm_front.sv
rtl/wrrm_engine.sv
rtl/weighted_run_region_merger_top.sv
rtl/wrrm_checker.sv
tb/sv/tb_top.sv
